/* rtl/core/dead_reckoning_position_integrator_macros.svh */
// Assertion macros for the dead-reckoning position integrator.
// Included by the top level; depends on nothing else.
`ifndef DEAD_RECKONING_POSITION_INTEGRATOR_MACROS_SVH
`define DEAD_RECKONING_POSITION_INTEGRATOR_MACROS_SVH

// same-cycle implication
`define DRPI_ASSERT_NOW(label, clk, rst, cond, chk) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (chk)) \
      else $error("drpi same-cycle check failed");

// next-cycle implication
`define DRPI_ASSERT_NEXT(label, clk, rst, cond, chk) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (chk)) \
      else $error("drpi next-cycle check failed");

`endif

/* rtl/core/drpi_pkg.sv */
// Constants, types and the arctangent table of the dead-reckoning integrator.
// Depends on nothing; imported by dead_reckoning_position_integrator.
`default_nettype none

package drpi_pkg;

   localparam int POS_W         = 32;
   localparam int ANGLE_W       = 16;
   localparam int CORDIC_STEPS  = 16;

   localparam int VEL_W         = 16;
   localparam int ANGLE_FIELD_W = 16;
   localparam int TIME_W        = 16;
   localparam int HEIGHT_W      = 32;
   localparam int OUT_W         = 32;

   localparam int PHASE_W       = 32;
   localparam int COEF_W        = 32;
   localparam int R_W           = 34;
   localparam int ACC_W         = 66;
   localparam int WIDE_W        = 64;
   localparam int DIGIT_W       = 4;
   localparam int PROD_W        = R_W + DIGIT_W + 1;
   localparam int VPROD_W       = VEL_W + DIGIT_W + 1;
   localparam int FRAC_SHIFT    = 30;
   localparam int OUT_SHIFT     = 4;
   localparam int TIME_DIGITS   = TIME_W / DIGIT_W;
   localparam int COEF_DIGITS   = COEF_W / DIGIT_W;
   localparam int CNT_W         = $clog2((CORDIC_STEPS > COEF_DIGITS) ? CORDIC_STEPS
                                                                      : COEF_DIGITS);
   localparam int ATAN_IDX_W    = 5;
   localparam int ATAN_DEPTH    = 32;

   localparam logic OP_INTEGRATE = 1'b0;
   localparam logic OP_RESET_POS = 1'b1;

   typedef logic signed [COEF_W-1:0]  coef_type;
   typedef logic signed [PHASE_W-1:0] phase_type;
   typedef logic signed [R_W-1:0]     rval_type;
   typedef logic signed [ACC_W-1:0]   acc_type;
   typedef logic signed [POS_W-1:0]   pos_type;
   typedef logic signed [WIDE_W-1:0]  wide_type;

   typedef struct packed {
      coef_type   x;
      coef_type   y;
      phase_type  z;
      logic [1:0] quad;
   } cordic_lane_type;

   localparam logic [PHASE_W-1:0] PHASE_KEEP =
      ~((PHASE_W'(1) << (PHASE_W - ANGLE_W)) - PHASE_W'(1));
   localparam logic [PHASE_W-1:0] EIGHTH_TURN = PHASE_W'(1) << (PHASE_W - 3);
   localparam coef_type CORDIC_GAIN = 32'sh26DD3B6A;

   localparam acc_type  HALF_Q30 = ACC_W'(1) << (FRAC_SHIFT - 1);
   localparam wide_type OUT_HALF = WIDE_W'(1) << (OUT_SHIFT - 1);
   localparam wide_type POS_MAX  = (WIDE_W'(1) << (POS_W - 1)) - WIDE_W'(1);
   localparam wide_type POS_MIN  = -POS_MAX - WIDE_W'(1);
   localparam wide_type OUT_MAX  = (WIDE_W'(1) << (OUT_W - 1)) - WIDE_W'(1);
   localparam wide_type OUT_MIN  = -OUT_MAX - WIDE_W'(1);

   localparam phase_type ATAN_TAB [ATAN_DEPTH] = '{
      32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
      32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
      32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
      32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
      32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
      32'sd652,       32'sd326,       32'sd163,       32'sd81,
      32'sd41,        32'sd20,        32'sd10,        32'sd5,
      32'sd3,         32'sd1,         32'sd1,         32'sd0
   };

endpackage

`default_nettype wire

/* rtl/core/dead_reckoning_position_integrator.sv */
// Dead-reckoning position integrator: CORDIC sin/cos, radix-16 digit-serial
// rotation multiplier and saturating position store. Uses drpi_pkg and the macro header.
//
//   channel  ports                         direction  moves
//   req      req_valid / req_stall         in         one operation item
//   rsp      rsp_valid / rsp_stall         out        one position item per request
//
// An integrate item runs 16 CORDIC iterations for roll, pitch and yaw in three lanes
// (velocity times time digit-serial in the first 4), then three rotations through the
// radix-16 multiplier (8 coefficient digits) in S_LOAD, S_ROT and S_WB, then updates
// the position in S_FINISH once rsp is free, and returns to S_IDLE to accept.
// A reset-position item skips to S_FINISH. Reset clears the position and empties rsp.
// A stalled rsp holds its item; the next item is accepted and waits to update the position.
`default_nettype none
`include "dead_reckoning_position_integrator_macros.svh"

module dead_reckoning_position_integrator (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic                                        req_opcode,
   input  logic signed [drpi_pkg::VEL_W-1:0]           req_vel_x,
   input  logic signed [drpi_pkg::VEL_W-1:0]           req_vel_y,
   input  logic signed [drpi_pkg::VEL_W-1:0]           req_vel_z,
   input  logic signed [drpi_pkg::ANGLE_FIELD_W-1:0]   req_roll_angle,
   input  logic signed [drpi_pkg::ANGLE_FIELD_W-1:0]   req_pitch_angle,
   input  logic signed [drpi_pkg::ANGLE_FIELD_W-1:0]   req_yaw_angle,
   input  logic        [drpi_pkg::TIME_W-1:0]          req_elapsed_time,
   input  logic signed [drpi_pkg::HEIGHT_W-1:0]        req_start_height,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic signed [drpi_pkg::OUT_W-1:0]           rsp_pos_x,
   output logic signed [drpi_pkg::OUT_W-1:0]           rsp_pos_y,
   output logic signed [drpi_pkg::OUT_W-1:0]           rsp_pos_z
);
   import drpi_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CORDIC = 3'd1;
   localparam logic [2:0] S_LOAD   = 3'd2;
   localparam logic [2:0] S_ROT    = 3'd3;
   localparam logic [2:0] S_WB     = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   localparam logic [1:0] STAGE_ROLL  = 2'd0;
   localparam logic [1:0] STAGE_PITCH = 2'd1;
   localparam logic [1:0] STAGE_YAW   = 2'd2;

   function automatic cordic_lane_type cordic_init(
      input logic signed [ANGLE_FIELD_W-1:0] ang);
      logic [PHASE_W-1:0] p;
      logic [PHASE_W-1:0] biased;
      cordic_lane_type    l;
      p      = {ang, {(PHASE_W - ANGLE_FIELD_W){1'b0}}} & PHASE_KEEP;
      biased = p + EIGHTH_TURN;
      l.quad = biased[PHASE_W-1 -: 2];
      l.z    = $signed(p - {l.quad, {(PHASE_W - 2){1'b0}}});
      l.x    = CORDIC_GAIN;
      l.y    = '0;
      return l;
   endfunction

   function automatic cordic_lane_type cordic_step(
      input cordic_lane_type l, input logic [CNT_W-1:0] k);
      coef_type        xs;
      coef_type        ys;
      phase_type       a;
      cordic_lane_type n;
      xs     = l.x >>> k;
      ys     = l.y >>> k;
      a      = ATAN_TAB[ATAN_IDX_W'(k)];
      n.quad = l.quad;
      if (!l.z[PHASE_W-1]) begin
         n.x = l.x - ys;
         n.y = l.y + xs;
         n.z = l.z - a;
      end else begin
         n.x = l.x + ys;
         n.y = l.y - xs;
         n.z = l.z + a;
      end
      return n;
   endfunction

   function automatic coef_type lane_cos(input cordic_lane_type l);
      coef_type c;
      case (l.quad)
         2'd0: c = l.x;
         2'd1: c = -l.y;
         2'd2: c = -l.x;
         default: c = l.y;
      endcase
      return c;
   endfunction

   function automatic coef_type lane_sin(input cordic_lane_type l);
      coef_type s;
      case (l.quad)
         2'd0: s = l.y;
         2'd1: s = l.x;
         2'd2: s = -l.y;
         default: s = -l.x;
      endcase
      return s;
   endfunction

   function automatic pos_type sat_pos(input wide_type v);
      wide_type c;
      if (v > POS_MAX) begin
         c = POS_MAX;
      end else if (v < POS_MIN) begin
         c = POS_MIN;
      end else begin
         c = v;
      end
      return POS_W'(c);
   endfunction

   function automatic logic signed [OUT_W-1:0] sat_out(input pos_type p);
      wide_type v;
      wide_type c;
      v = WIDE_W'(p);
      if (v > OUT_MAX) begin
         c = OUT_MAX;
      end else if (v < OUT_MIN) begin
         c = OUT_MIN;
      end else begin
         c = v;
      end
      return OUT_W'(c);
   endfunction

   function automatic pos_type pos_update(
      input logic op, input rval_type r, input pos_type p);
      wide_type w;
      if (op == OP_RESET_POS) begin
         w = WIDE_W'(r);
      end else begin
         w = WIDE_W'(p) + ((WIDE_W'(r) + OUT_HALF) >>> OUT_SHIFT);
      end
      return sat_pos(w);
   endfunction

   logic [2:0]                 state_ff, state_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [1:0]                 stage_ff, stage_in;
   logic                       op_ff, op_in;
   logic signed [VEL_W-1:0]    vel_x_ff, vel_x_in;
   logic signed [VEL_W-1:0]    vel_y_ff, vel_y_in;
   logic signed [VEL_W-1:0]    vel_z_ff, vel_z_in;
   logic [TIME_W-1:0]          time_ff, time_in;
   cordic_lane_type            roll_ff, roll_in;
   cordic_lane_type            pitch_ff, pitch_in;
   cordic_lane_type            yaw_ff, yaw_in;
   rval_type                   rx_ff, rx_in;
   rval_type                   ry_ff, ry_in;
   rval_type                   rz_ff, rz_in;
   coef_type                   coef_c_ff, coef_c_in;
   coef_type                   coef_s_ff, coef_s_in;
   acc_type                    acc_a_ff, acc_a_in;
   acc_type                    acc_b_ff, acc_b_in;
   pos_type                    pos_x_ff, pos_x_in;
   pos_type                    pos_y_ff, pos_y_in;
   pos_type                    pos_z_ff, pos_z_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]    rsp_pos_x_ff, rsp_pos_x_in;
   logic signed [OUT_W-1:0]    rsp_pos_y_ff, rsp_pos_y_in;
   logic signed [OUT_W-1:0]    rsp_pos_z_ff, rsp_pos_z_in;

   logic                       accept;
   logic                       rsp_free;
   logic                       rot_last;
   cordic_lane_type            lane_sel;
   rval_type                   rot_p;
   rval_type                   rot_q;
   logic signed [DIGIT_W:0]    dig_c;
   logic signed [DIGIT_W:0]    dig_s;
   logic signed [PROD_W-1:0]   prod_cp, prod_sq, prod_cq, prod_sp;
   acc_type                    round_add;
   logic [DIGIT_W-1:0]         time_dig;
   logic signed [VPROD_W-1:0]  prod_vx, prod_vy, prod_vz;
   rval_type                   res_a;
   rval_type                   res_b;
   pos_type                    new_x, new_y, new_z;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rot_last  = (cnt_ff == CNT_W'(COEF_DIGITS - 1));

   always_comb begin
      case (stage_ff)
         STAGE_ROLL: begin
            lane_sel = roll_ff;
            rot_p    = ry_ff;
            rot_q    = rz_ff;
         end
         STAGE_PITCH: begin
            lane_sel = pitch_ff;
            rot_p    = rz_ff;
            rot_q    = rx_ff;
         end
         default: begin
            lane_sel = yaw_ff;
            rot_p    = rx_ff;
            rot_q    = ry_ff;
         end
      endcase
   end

   always_comb begin
      if (cnt_ff == '0) begin
         dig_c = {coef_c_ff[COEF_W-1], coef_c_ff[COEF_W-1 -: DIGIT_W]};
         dig_s = {coef_s_ff[COEF_W-1], coef_s_ff[COEF_W-1 -: DIGIT_W]};
      end else begin
         dig_c = {1'b0, coef_c_ff[COEF_W-1 -: DIGIT_W]};
         dig_s = {1'b0, coef_s_ff[COEF_W-1 -: DIGIT_W]};
      end
   end

   assign prod_cp   = dig_c * rot_p;
   assign prod_sq   = dig_s * rot_q;
   assign prod_cq   = dig_c * rot_q;
   assign prod_sp   = dig_s * rot_p;
   assign round_add = rot_last ? HALF_Q30 : '0;

   assign time_dig = time_ff[TIME_W-1 -: DIGIT_W];
   assign prod_vx  = $signed({1'b0, time_dig}) * vel_x_ff;
   assign prod_vy  = $signed({1'b0, time_dig}) * vel_y_ff;
   assign prod_vz  = $signed({1'b0, time_dig}) * vel_z_ff;

   assign res_a = acc_a_ff[FRAC_SHIFT + R_W - 1 : FRAC_SHIFT];
   assign res_b = acc_b_ff[FRAC_SHIFT + R_W - 1 : FRAC_SHIFT];

   assign new_x = pos_update(op_ff, rx_ff, pos_x_ff);
   assign new_y = pos_update(op_ff, ry_ff, pos_y_ff);
   assign new_z = pos_update(op_ff, rz_ff, pos_z_ff);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      stage_in     = stage_ff;
      op_in        = op_ff;
      vel_x_in     = vel_x_ff;
      vel_y_in     = vel_y_ff;
      vel_z_in     = vel_z_ff;
      time_in      = time_ff;
      roll_in      = roll_ff;
      pitch_in     = pitch_ff;
      yaw_in       = yaw_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      rz_in        = rz_ff;
      coef_c_in    = coef_c_ff;
      coef_s_in    = coef_s_ff;
      acc_a_in     = acc_a_ff;
      acc_b_in     = acc_b_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      pos_z_in     = pos_z_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pos_x_in = rsp_pos_x_ff;
      rsp_pos_y_in = rsp_pos_y_ff;
      rsp_pos_z_in = rsp_pos_z_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_opcode;
               vel_x_in = req_vel_x;
               vel_y_in = req_vel_y;
               vel_z_in = req_vel_z;
               time_in  = req_elapsed_time;
               roll_in  = cordic_init(req_roll_angle);
               pitch_in = cordic_init(req_pitch_angle);
               yaw_in   = cordic_init(req_yaw_angle);
               rx_in    = '0;
               ry_in    = '0;
               cnt_in   = '0;
               stage_in = STAGE_ROLL;
               if (req_opcode == OP_RESET_POS) begin
                  rz_in    = R_W'(req_start_height);
                  state_in = S_FINISH;
               end else begin
                  rz_in    = '0;
                  state_in = S_CORDIC;
               end
            end
         end
         S_CORDIC: begin
            roll_in  = cordic_step(roll_ff, cnt_ff);
            pitch_in = cordic_step(pitch_ff, cnt_ff);
            yaw_in   = cordic_step(yaw_ff, cnt_ff);
            if (cnt_ff < CNT_W'(TIME_DIGITS)) begin
               rx_in   = (rx_ff <<< DIGIT_W) + R_W'(prod_vx);
               ry_in   = (ry_ff <<< DIGIT_W) + R_W'(prod_vy);
               rz_in   = (rz_ff <<< DIGIT_W) + R_W'(prod_vz);
               time_in = time_ff << DIGIT_W;
            end
            if (cnt_ff == CNT_W'(CORDIC_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = S_LOAD;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_LOAD: begin
            coef_c_in = lane_cos(lane_sel);
            coef_s_in = lane_sin(lane_sel);
            acc_a_in  = '0;
            acc_b_in  = '0;
            cnt_in    = '0;
            state_in  = S_ROT;
         end
         S_ROT: begin
            acc_a_in  = (acc_a_ff <<< DIGIT_W) + ACC_W'(prod_cp) - ACC_W'(prod_sq) + round_add;
            acc_b_in  = (acc_b_ff <<< DIGIT_W) + ACC_W'(prod_cq) + ACC_W'(prod_sp) + round_add;
            coef_c_in = coef_c_ff << DIGIT_W;
            coef_s_in = coef_s_ff << DIGIT_W;
            if (rot_last) begin
               state_in = S_WB;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_WB: begin
            case (stage_ff)
               STAGE_ROLL: begin
                  ry_in = res_a;
                  rz_in = res_b;
               end
               STAGE_PITCH: begin
                  rz_in = res_a;
                  rx_in = res_b;
               end
               default: begin
                  rx_in = res_a;
                  ry_in = res_b;
               end
            endcase
            if (stage_ff == STAGE_YAW) begin
               state_in = S_FINISH;
            end else begin
               stage_in = stage_ff + 2'd1;
               state_in = S_LOAD;
            end
         end
         S_FINISH: begin
            if (rsp_free) begin
               pos_x_in     = new_x;
               pos_y_in     = new_y;
               pos_z_in     = new_z;
               rsp_pos_x_in = sat_out(new_x);
               rsp_pos_y_in = sat_out(new_y);
               rsp_pos_z_in = sat_out(new_z);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         stage_ff     <= STAGE_ROLL;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         pos_z_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         stage_ff     <= stage_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         pos_z_ff     <= pos_z_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      vel_x_ff     <= vel_x_in;
      vel_y_ff     <= vel_y_in;
      vel_z_ff     <= vel_z_in;
      time_ff      <= time_in;
      roll_ff      <= roll_in;
      pitch_ff     <= pitch_in;
      yaw_ff       <= yaw_in;
      rx_ff        <= rx_in;
      ry_ff        <= ry_in;
      rz_ff        <= rz_in;
      coef_c_ff    <= coef_c_in;
      coef_s_ff    <= coef_s_in;
      acc_a_ff     <= acc_a_in;
      acc_b_ff     <= acc_b_in;
      rsp_pos_x_ff <= rsp_pos_x_in;
      rsp_pos_y_ff <= rsp_pos_y_in;
      rsp_pos_z_ff <= rsp_pos_z_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_x = rsp_pos_x_ff;
   assign rsp_pos_y = rsp_pos_y_ff;
   assign rsp_pos_z = rsp_pos_z_ff;

   `DRPI_ASSERT_NEXT(a_integrate_starts_cordic, clock, reset,
      accept && (req_opcode == OP_INTEGRATE),
      (state_ff == S_CORDIC) && (cnt_ff == CNT_W'(0)))
   `DRPI_ASSERT_NEXT(a_result_only_from_finish, clock, reset,
      state_ff != S_FINISH, !$rose(rsp_valid_ff))
   `DRPI_ASSERT_NEXT(a_finish_waits_for_slot, clock, reset,
      (state_ff == S_FINISH) && rsp_valid_ff && rsp_stall, state_ff == S_FINISH)
   `DRPI_ASSERT_NEXT(a_rotation_runs_all_digits, clock, reset,
      (state_ff == S_ROT) && !rot_last, state_ff == S_ROT)

endmodule

`default_nettype wire
